// ===== rtl/jtsm_pkg.sv =====
package jtsm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SQ_W      = 32;
    localparam int R_W       = 17;
    localparam int FS_W      = 15;
    localparam int DLY_W     = 20;
    localparam int U_W       = FRAC_BITS + 1;
    localparam int RFS_W     = R_W + FS_W;
    localparam int RN_W      = R_W + FRAC_BITS;
    localparam int DN_W      = SQ_W + FRAC_BITS;

    localparam logic [1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [1:0] REG_SLOWEST    = 2'd1;
    localparam logic [1:0] REG_SLOPE      = 2'd2;

    typedef struct packed {
        logic             skipped;
        logic             first_r;
        logic             dneg;
        logic             ypos;
        logic [SQ_W-1:0]  s;
        logic [SQ_W-1:0]  d;
    } sq_word_t;

    typedef struct packed {
        logic             skipped;
        logic             first_r;
        logic             dneg;
        logic             ypos;
        logic [R_W-1:0]   r;
        logic [SQ_W-1:0]  d;
    } rt_word_t;

    typedef struct packed {
        logic             skipped;
        logic             first_r;
        logic             dneg;
        logic             ypos;
        logic [U_W-1:0]   u_r;
        logic [U_W-1:0]   u_d;
    } uq_word_t;

    typedef struct packed {
        logic             skipped;
        logic             first_dir;
        logic             first_step;
        logic [DLY_W-1:0] first_delay_us;
        logic             second_dir;
        logic             second_step;
        logic [DLY_W-1:0] second_delay_us;
    } res_word_t;

endpackage

// ===== rtl/jtsm_sqrt.sv =====
module jtsm_sqrt import jtsm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     adv,
    input  logic     in_valid,
    input  sq_word_t in_word,
    output logic     out_valid,
    output rt_word_t out_word
);

    localparam int NST = R_W - 1;

    logic     [NST:0]       vld_reg;
    sq_word_t               wd_reg  [NST+1];
    logic     [SQ_W:0]      rem_reg [NST+1];
    logic     [R_W-1:0]     res_reg [NST+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wd_reg[0]  <= in_word;
            rem_reg[0] <= {1'b0, in_word.s};
            res_reg[0] <= '0;
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        localparam int B = NST - 1 - g;
        logic [SQ_W+1:0] trial;
        logic [SQ_W+1:0] cand;
        always_comb begin
            cand  = ({{(SQ_W+2-R_W){1'b0}}, res_reg[g]} << (B + 1))
                  + ({{(SQ_W+1){1'b0}}, 1'b1} << (2 * B));
            trial = {1'b0, rem_reg[g]} - cand;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                wd_reg[g+1] <= wd_reg[g];
                if (!trial[SQ_W+1]) begin
                    rem_reg[g+1] <= trial[SQ_W:0];
                    res_reg[g+1] <= res_reg[g] | (R_W'(1) << B);
                end else begin
                    rem_reg[g+1] <= rem_reg[g];
                    res_reg[g+1] <= res_reg[g];
                end
            end
        end
    end

    assign out_valid        = vld_reg[NST];
    assign out_word.skipped = wd_reg[NST].skipped;
    assign out_word.first_r = wd_reg[NST].first_r;
    assign out_word.dneg    = wd_reg[NST].dneg;
    assign out_word.ypos    = wd_reg[NST].ypos;
    assign out_word.d       = wd_reg[NST].d;
    assign out_word.r       = res_reg[NST];

endmodule

// ===== rtl/jtsm_div.sv =====
module jtsm_div import jtsm_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic [FS_W-1:0] fs,
    input  logic            in_valid,
    input  rt_word_t        in_word,
    output logic            out_valid,
    output uq_word_t        out_word
);

    localparam int NST = U_W + 1;

    logic     [NST:0]       vld_reg;
    rt_word_t               wd_reg  [NST+1];
    logic     [RFS_W-1:0]   den_reg [NST+1];
    logic     [RN_W-1:0]    nr_reg  [NST+1];
    logic     [DN_W-1:0]    nd_reg  [NST+1];
    logic     [U_W-1:0]     qr_reg  [NST+1];
    logic     [U_W-1:0]     qd_reg  [NST+1];
    logic                   ovr_reg [NST+1];
    logic                   ovd_reg [NST+1];
    logic     [FS_W-1:0]    fse;

    assign fse = (fs == '0) ? FS_W'(1) : fs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wd_reg[0]  <= in_word;
            den_reg[0] <= RFS_W'(in_word.r) * RFS_W'(fse);
            nr_reg[0]  <= {in_word.r, {FRAC_BITS{1'b0}}};
            nd_reg[0]  <= {in_word.d, {FRAC_BITS{1'b0}}};
            qr_reg[0]  <= '0;
            qd_reg[0]  <= '0;
            ovr_reg[0] <= 1'b0;
            ovd_reg[0] <= 1'b0;
        end
    end

    for (genvar g = 0; g < NST; g++) begin : g_st
        localparam int B = NST - 1 - g;
        logic [RN_W+B:0]  sr;
        logic [DN_W+RFS_W+B:0] sd;
        logic             ger, ged;
        always_comb begin
            if (B >= U_W) begin
                sr = '0; sd = '0; ger = 1'b0; ged = 1'b0;
            end else begin
                sr  = (RN_W+B+1)'(fse) << B;
                sd  = (DN_W+RFS_W+B+1)'(den_reg[g]) << B;
                ger = (RN_W+B+1)'(nr_reg[g]) >= sr;
                ged = (DN_W+RFS_W+B+1)'(nd_reg[g]) >= sd;
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                wd_reg[g+1]  <= wd_reg[g];
                den_reg[g+1] <= den_reg[g];
                if (B >= U_W) begin
                    ovr_reg[g+1] <= (RN_W+1)'(nr_reg[g]) >=
                                    ((RN_W+1)'(fse) << U_W);
                    ovd_reg[g+1] <= (DN_W+RFS_W+1)'(nd_reg[g]) >=
                                    ((DN_W+RFS_W+1)'(den_reg[g]) << U_W);
                    nr_reg[g+1]  <= nr_reg[g];
                    nd_reg[g+1]  <= nd_reg[g];
                    qr_reg[g+1]  <= qr_reg[g];
                    qd_reg[g+1]  <= qd_reg[g];
                end else begin
                    ovr_reg[g+1] <= ovr_reg[g];
                    ovd_reg[g+1] <= ovd_reg[g];
                    nr_reg[g+1]  <= ger ? RN_W'((RN_W+B+1)'(nr_reg[g]) - sr)
                                        : nr_reg[g];
                    nd_reg[g+1]  <= ged ? DN_W'((DN_W+RFS_W+B+1)'(nd_reg[g]) - sd)
                                        : nd_reg[g];
                    qr_reg[g+1]  <= qr_reg[g] | (U_W'(ger) << B);
                    qd_reg[g+1]  <= qd_reg[g] | (U_W'(ged) << B);
                end
            end
        end
    end

    localparam logic [U_W-1:0] ONE = U_W'(1) << FRAC_BITS;

    assign out_valid        = vld_reg[NST];
    assign out_word.skipped = wd_reg[NST].skipped;
    assign out_word.first_r = wd_reg[NST].first_r;
    assign out_word.dneg    = wd_reg[NST].dneg;
    assign out_word.ypos    = wd_reg[NST].ypos;
    assign out_word.u_r     = (ovr_reg[NST] || qr_reg[NST] > ONE) ? ONE : qr_reg[NST];
    assign out_word.u_d     = (ovd_reg[NST] || qd_reg[NST] > ONE) ? ONE : qd_reg[NST];

endmodule

// ===== rtl/jtsm_delay.sv =====
module jtsm_delay import jtsm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  logic [DLY_W-1:0] slowest,
    input  logic [DLY_W-1:0] slope,
    input  logic             in_valid,
    input  uq_word_t         in_word,
    output logic             out_valid,
    output res_word_t        out_word
);

    localparam int P_W = DLY_W + U_W;

    logic             vld_reg;
    uq_word_t         wd_reg;
    logic [P_W-1:0]   p1_reg, p2_reg;
    logic [U_W-1:0]   u1, u2;
    logic [DLY_W:0]   red1, red2;
    logic             neg1, neg2;

    assign u1 = in_word.first_r ? in_word.u_r : in_word.u_d;
    assign u2 = in_word.first_r ? in_word.u_d : in_word.u_r;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wd_reg <= in_word;
            p1_reg <= P_W'(slope) * P_W'(u1);
            p2_reg <= P_W'(slope) * P_W'(u2);
        end
    end

    assign red1 = (DLY_W+1)'(p1_reg >> FRAC_BITS);
    assign red2 = (DLY_W+1)'(p2_reg >> FRAC_BITS);

    always_comb begin
        if (wd_reg.ypos) begin
            neg1 = wd_reg.first_r ? 1'b0 : wd_reg.dneg;
            neg2 = wd_reg.first_r ? wd_reg.dneg : 1'b0;
        end else begin
            neg1 = wd_reg.first_r ? 1'b1 : !wd_reg.dneg;
            neg2 = wd_reg.first_r ? !wd_reg.dneg : 1'b1;
        end
    end

    logic [U_W-1:0] v1, v2;
    assign v1 = wd_reg.first_r ? wd_reg.u_r : wd_reg.u_d;
    assign v2 = wd_reg.first_r ? wd_reg.u_d : wd_reg.u_r;

    always_comb begin
        out_word = '0;
        if (wd_reg.skipped) begin
            out_word.skipped = 1'b1;
        end else begin
            out_word.first_dir  = neg1;
            out_word.second_dir = !neg2;
            out_word.first_step = v1 != '0;
            out_word.second_step = v2 != '0;
            if (v1 != '0 && red1 < (DLY_W+1)'(slowest)) begin
                out_word.first_delay_us = DLY_W'((DLY_W+1)'(slowest) - red1);
            end
            if (v2 != '0 && red2 < (DLY_W+1)'(slowest)) begin
                out_word.second_delay_us = DLY_W'((DLY_W+1)'(slowest) - red2);
            end
        end
    end

    assign out_valid = vld_reg;

endmodule

// ===== rtl/joystick_to_track_step_mixer.sv =====
// Joystick to differential-drive track step mixer.
// Slave stream s_*: one word per joystick sample, s_tdata = {stick_y, stick_x}
// (stick_x in bits 15:0). Master stream m_*: one word per sample carrying
// direction, step flag and step delay for both tracks in m_tdata, and the
// skip flag for diagonal or centred sticks in m_tuser.
// APB port: full_scale at 0x0, slowest_delay_us at 0x4, delay_slope_us at 0x8.
// Each word passes through the input and squaring registers, the 17-stage
// square-root pipeline, the 19-stage restoring divider pipeline, one
// multiply stage and the output register on its way to m_tvalid.
// Throughput: one word per cycle; the pipeline is a single chain that
// advances whenever the output register is empty or being read.
// When m_tready is low with a word held, the whole chain holds and s_tready
// falls; nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// register defaults 32767, 2000 and 1000.
// Write configuration only while the pipeline is empty.
module joystick_to_track_step_mixer import jtsm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // stick_x[15:0], stick_y[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // first_dir, first_step, first_delay_us[21:2],
                                   // second_dir, second_step,
                                   // second_delay_us[43:24], zeros
    output logic        m_tuser,   // skipped
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [FS_W-1:0]  fs_reg;
    logic [DLY_W-1:0] slow_reg, slope_reg;
    logic [1:0]       ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg    <= FS_W'(32767);
            slow_reg  <= DLY_W'(2000);
            slope_reg <= DLY_W'(1000);
        end else if (psel && penable && pwrite && pready) begin
            unique case (ridx)
                REG_FULL_SCALE: fs_reg    <= pwdata[FS_W-1:0];
                REG_SLOWEST:    slow_reg  <= pwdata[DLY_W-1:0];
                REG_SLOPE:      slope_reg <= pwdata[DLY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ridx)
            REG_FULL_SCALE: prdata = 32'(fs_reg);
            REG_SLOWEST:    prdata = 32'(slow_reg);
            REG_SLOPE:      prdata = 32'(slope_reg);
            default:        prdata = '0;
        endcase
    end

    logic adv;
    logic in_vld_reg, sq_vld_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [SQ_W-1:0] xx_reg, yy_reg;
    logic skp_reg, fr_reg, yp_reg;
    sq_word_t sq_word;
    logic rt_vld, uq_vld, res_vld;
    rt_word_t rt_word;
    uq_word_t uq_word;
    res_word_t res_word;
    logic out_vld_reg;
    res_word_t out_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            sq_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            in_vld_reg  <= s_tvalid;
            sq_vld_reg  <= in_vld_reg;
            out_vld_reg <= res_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg   <= s_tdata[15:0];
            y_reg   <= s_tdata[31:16];
            xx_reg  <= SQ_W'(x_reg) * SQ_W'(x_reg);
            yy_reg  <= SQ_W'(y_reg) * SQ_W'(y_reg);
            skp_reg <= (x_reg == y_reg) || (17'(x_reg) == -17'(y_reg))
                       && ({x_reg[15], x_reg} == -{y_reg[15], y_reg});
            fr_reg  <= (y_reg[15] == x_reg[15]);
            yp_reg  <= !y_reg[15];
            out_reg <= res_word;
        end
    end

    assign sq_word.skipped = skp_reg;
    assign sq_word.first_r = fr_reg;
    assign sq_word.ypos    = yp_reg;
    assign sq_word.dneg    = yy_reg < xx_reg;
    assign sq_word.s       = xx_reg + yy_reg;
    assign sq_word.d       = (yy_reg < xx_reg) ? xx_reg - yy_reg : yy_reg - xx_reg;

    jtsm_sqrt u_sqrt (
        .aclk, .aresetn, .adv,
        .in_valid (sq_vld_reg), .in_word (sq_word),
        .out_valid (rt_vld), .out_word (rt_word)
    );

    jtsm_div u_div (
        .aclk, .aresetn, .adv, .fs (fs_reg),
        .in_valid (rt_vld), .in_word (rt_word),
        .out_valid (uq_vld), .out_word (uq_word)
    );

    jtsm_delay u_delay (
        .aclk, .aresetn, .adv, .slowest (slow_reg), .slope (slope_reg),
        .in_valid (uq_vld), .in_word (uq_word),
        .out_valid (res_vld), .out_word (res_word)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.skipped;
    assign m_tdata  = {4'b0,
                       out_reg.second_delay_us, out_reg.second_step,
                       out_reg.second_dir, out_reg.first_delay_us,
                       out_reg.first_step, out_reg.first_dir};

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
    endproperty
    assert property (p_hold) else $error("result changed under stall");

    property p_ready;
        @(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready);
    endproperty
    assert property (p_ready) else $error("ready not tied to output slot");

    property p_skip;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tdata == '0;
    endproperty
    assert property (p_skip) else $error("skipped word carries data");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    import jtsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        bit                 typed;
        res_word_t          res;
    } stick_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [14:0] fs_cfg;
    logic [19:0] slow_cfg;
    logic [19:0] slope_cfg;

    res_word_t   pending_tracks[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    joystick_to_track_step_mixer dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint floor_root(longint v);
        longint res, cand;
        res = 0;
        for (int i = 16; i >= 0; i--) begin
            cand = res | (longint'(1) << i);
            if (cand * cand <= v) res = cand;
        end
        return res;
    endfunction

    function automatic void track_speed(longint u, output logic step, output logic [19:0] dly);
        longint one, red;
        one = longint'(1) << FRAC_BITS;
        if (u > one) u = one;
        step = 1'b0;
        dly  = '0;
        if (u != 0) begin
            red  = (longint'(slope_cfg) * u) >> FRAC_BITS;
            step = 1'b1;
            dly  = (red >= longint'(slow_cfg)) ? 20'd0 : 20'(longint'(slow_cfg) - red);
        end
    endfunction

    function automatic res_word_t mix_tracks(logic signed [15:0] sx, logic signed [15:0] sy);
        longint x, y, xx, yy, r, d, fs, ur, ud;
        bit dneg, ypos, first_r, neg1, neg2;
        res_word_t w;
        w = '0;
        x = sx;
        y = sy;
        if (x == y || x == -y) begin
            w.skipped = 1'b1;
            return w;
        end
        xx = x * x;
        yy = y * y;
        r = floor_root(xx + yy);
        fs = (fs_cfg == 0) ? 1 : longint'(fs_cfg);
        dneg = yy < xx;
        d = dneg ? xx - yy : yy - xx;
        ur = (r << FRAC_BITS) / fs;
        ud = (d << FRAC_BITS) / (r * fs);
        ypos = y >= 0;
        first_r = (ypos == (x >= 0));
        if (ypos) begin
            neg1 = first_r ? 1'b0 : dneg;
            neg2 = first_r ? dneg : 1'b0;
        end else begin
            neg1 = first_r ? 1'b1 : !dneg;
            neg2 = first_r ? !dneg : 1'b1;
        end
        track_speed(first_r ? ur : ud, w.first_step, w.first_delay_us);
        track_speed(first_r ? ud : ur, w.second_step, w.second_delay_us);
        w.first_dir  = neg1;
        w.second_dir = !neg2;
        return w;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FULL_SCALE: fs_cfg    = value[14:0];
            REG_SLOWEST:    slow_cfg  = value[19:0];
            REG_SLOPE:      slope_cfg = value[19:0];
            default: ;
        endcase
    endtask

    task automatic send_word(logic signed [15:0] x, logic signed [15:0] y, bit typed,
                             res_word_t res);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
        pending_tracks.push_back(typed ? res : mix_tracks(x, y));
    endtask

    task automatic random_words(int n);
        logic signed [15:0] x, y;
        for (int i = 0; i < n; i++) begin
            x = 16'($urandom);
            y = 16'($urandom);
            case ($urandom_range(0, 7))
                0: begin
                    x = 16'($urandom_range(0, 15)) - 16'sd8;
                    y = 16'($urandom_range(0, 15)) - 16'sd8;
                end
                1: y = ($urandom_range(0, 1) != 0) ? x : -x;
                2: y = x + 16'($urandom_range(0, 2)) - 16'sd1;
                3: begin
                    x = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
                    y = 16'($urandom_range(0, 255)) - 16'sd128;
                end
                default: ;
            endcase
            send_word(x, y, 1'b0, '0);
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_tracks.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    stick_row_t rows[$];

    initial begin
        rows = '{
            '{16'sd0,      16'sd0,      1'b1, res_word_t'{1'b1, 1'b0, 1'b0, 20'd0, 1'b0, 1'b0, 20'd0}},
            '{16'sd5,      16'sd5,      1'b1, res_word_t'{1'b1, 1'b0, 1'b0, 20'd0, 1'b0, 1'b0, 20'd0}},
            '{-16'sd7,     16'sd7,      1'b1, res_word_t'{1'b1, 1'b0, 1'b0, 20'd0, 1'b0, 1'b0, 20'd0}},
            '{16'sh8000,   16'sh8000,   1'b1, res_word_t'{1'b1, 1'b0, 1'b0, 20'd0, 1'b0, 1'b0, 20'd0}},
            '{16'sh7fff,   -16'sh7fff,  1'b1, res_word_t'{1'b1, 1'b0, 1'b0, 20'd0, 1'b0, 1'b0, 20'd0}},
            '{16'sd0,      16'sh7fff,   1'b1, res_word_t'{1'b0, 1'b0, 1'b1, 20'd1000, 1'b1, 1'b1, 20'd1000}},
            '{16'sd0,      16'sh8000,   1'b0, '0},
            '{16'sh8000,   16'sd0,      1'b0, '0},
            '{16'sh7fff,   16'sd0,      1'b0, '0},
            '{16'sh7fff,   16'sh8000,   1'b0, '0},
            '{16'sh8000,   16'sh7fff,   1'b0, '0},
            '{16'sd1,      16'sd0,      1'b0, '0},
            '{16'sd0,      -16'sd1,     1'b0, '0},
            '{-16'sd1,     16'sd2,      1'b0, '0},
            '{16'sd3,      -16'sd1,     1'b0, '0},
            '{-16'sd3,     -16'sd1,     1'b0, '0},
            '{-16'sd1,     -16'sd3,     1'b0, '0},
            '{16'sd1000,   16'sd1001,   1'b0, '0},
            '{-16'sd20000, 16'sd19999,  1'b0, '0},
            '{16'sh5555,   -16'sh2aaa,  1'b0, '0}
        };
        fs_cfg    = 15'd32767;
        slow_cfg  = 20'd2000;
        slope_cfg = 20'd1000;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_word(rows[i].x, rows[i].y, rows[i].typed, rows[i].res);
        random_words(80);
        drain();

        apb_write(REG_FULL_SCALE, 32'd1);
        apb_write(REG_SLOWEST, 32'hfffff);
        apb_write(REG_SLOPE, 32'hfffff);
        hold_req = 1'b1;
        random_words(120);
        drain();

        apb_write(REG_FULL_SCALE, 32'd32767);
        apb_write(REG_SLOWEST, 32'd0);
        apb_write(REG_SLOPE, 32'hfffff);
        random_words(100);
        drain();

        apb_write(REG_FULL_SCALE, 32'd0);
        apb_write(REG_SLOWEST, 32'd500);
        apb_write(REG_SLOPE, 32'd0);
        apb_write(REG_SPARE, 32'hffffffff);
        random_words(100);
        drain();

        apb_write(REG_FULL_SCALE, $urandom_range(1, 32767));
        apb_write(REG_SLOWEST, $urandom_range(0, 20'hfffff));
        apb_write(REG_SLOPE, $urandom_range(0, 20'hfffff));
        random_words(120);
        drain();

        apb_write(REG_FULL_SCALE, 32'd1000);
        apb_write(REG_SLOWEST, 32'd2000);
        apb_write(REG_SLOPE, 32'd3000);
        quiet = 1'b1;
        random_words(110);
        drain();

        if (errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        res_word_t got, want;
        if (m_tvalid && m_tready) begin
            got.skipped         = m_tuser;
            got.first_dir       = m_tdata[0];
            got.first_step      = m_tdata[1];
            got.first_delay_us  = m_tdata[21:2];
            got.second_dir      = m_tdata[22];
            got.second_step     = m_tdata[23];
            got.second_delay_us = m_tdata[43:24];
            if (pending_tracks.size() == 0) begin
                report("unexpected word", longint'(m_tdata), 0);
            end else begin
                want = pending_tracks.pop_front();
                if (got.skipped != want.skipped) report("skipped", got.skipped, want.skipped);
                if (got.first_dir != want.first_dir)
                    report("first_dir", got.first_dir, want.first_dir);
                if (got.first_step != want.first_step)
                    report("first_step", got.first_step, want.first_step);
                if (got.first_delay_us != want.first_delay_us)
                    report("first_delay_us", got.first_delay_us, want.first_delay_us);
                if (got.second_dir != want.second_dir)
                    report("second_dir", got.second_dir, want.second_dir);
                if (got.second_step != want.second_step)
                    report("second_step", got.second_step, want.second_step);
                if (got.second_delay_us != want.second_delay_us)
                    report("second_delay_us", got.second_delay_us, want.second_delay_us);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== files.f =====
rtl/jtsm_pkg.sv
rtl/jtsm_sqrt.sv
rtl/jtsm_div.sv
rtl/jtsm_delay.sv
rtl/joystick_to_track_step_mixer.sv
bench/tb_top.sv
